// ===== sv/sorted_set_merge_engine_assert.svh =====
// Assertion macros shared by the sorted set merge engine RTL.
// Define ASSERT_OFF to compile the checks out; nothing else is required.
`ifndef SORTED_SET_MERGE_ENGINE_ASSERT_SVH
`define SORTED_SET_MERGE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SSME_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_set_merge_engine: same-cycle check failed");
`define SSME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_set_merge_engine: next-cycle check failed");
`else
`define SSME_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SSME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ssme_pkg.sv =====
// Shared types and constants for the sorted set merge engine.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package ssme_pkg;

    localparam int VALUE_W = 32;
    localparam int OPC_W   = 2;
    localparam int SETOP_W = 2;

    localparam logic [OPC_W-1:0] OPC_LOAD_A = 2'd0;
    localparam logic [OPC_W-1:0] OPC_LOAD_B = 2'd1;
    localparam logic [OPC_W-1:0] OPC_RUN    = 2'd2;

    localparam logic [SETOP_W-1:0] SETOP_MERGE     = 2'd0;
    localparam logic [SETOP_W-1:0] SETOP_UNION     = 2'd1;
    localparam logic [SETOP_W-1:0] SETOP_INTERSECT = 2'd2;
    localparam logic [SETOP_W-1:0] SETOP_DIFF      = 2'd3;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic walk_done;
    } t_dp_stat;

endpackage

// ===== sv/ssme_ctrl.sv =====
// Controller state machine of the sorted set merge engine.
// Depends on ssme_pkg; drives the datapath through t_dp_cmd.
`timescale 1ns / 1ps

module ssme_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [ssme_pkg::OPC_W-1:0]   i_s_tuser,
    output logic                         o_s_tready,
    input  ssme_pkg::t_dp_stat           i_stat,
    output ssme_pkg::t_dp_cmd            o_cmd
);
    import ssme_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_s_tuser)
                        OPC_LOAD_A: o_cmd.load_a = 1'b1;
                        OPC_LOAD_B: o_cmd.load_b = 1'b1;
                        OPC_RUN: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (i_stat.slot_free) begin
                    if (i_stat.walk_done) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/ssme_dp.sv =====
// Datapath of the sorted set merge engine: list storage, walk pointers and output word.
// Depends on ssme_pkg and sorted_set_merge_engine_assert.svh.
`timescale 1ns / 1ps

`include "sorted_set_merge_engine_assert.svh"

module ssme_dp #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ssme_pkg::t_dp_cmd              i_cmd,
    output ssme_pkg::t_dp_stat             o_stat,
    input  logic [ssme_pkg::VALUE_W-1:0]   i_value,
    input  logic                           i_cfg_wr_en,
    input  logic [ssme_pkg::SETOP_W-1:0]   i_cfg_wr_data,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [ssme_pkg::VALUE_W-1:0]   o_m_tdata,
    output logic                           o_m_tlast,
    output logic [1:0]                     o_m_tuser
);
    import ssme_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    logic [VALUE_W-1:0] mem_a [LIST_DEPTH];
    logic [VALUE_W-1:0] mem_b [LIST_DEPTH];

    logic [SETOP_W-1:0] r_setop;
    logic [CW-1:0]      r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]      r_i, n_i, r_j, n_j;
    logic               r_dropped, n_dropped;
    logic [VALUE_W-1:0] r_a, r_b;
    logic               r_pend_valid, n_pend_valid;
    logic [VALUE_W-1:0] r_pend_val, n_pend_val;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_val, n_out_val;
    logic               r_out_last, n_out_last;
    logic               r_out_empty, n_out_empty;
    logic               r_out_ovf, n_out_ovf;

    logic               has_a, has_b, a_lt_b, a_eq_b;
    logic               inc_i, inc_j, emit;
    logic [VALUE_W-1:0] emit_val;
    logic               a_full, b_full, push;

    assign has_a  = (r_i < r_cnt_a);
    assign has_b  = (r_j < r_cnt_b);
    assign a_lt_b = ($signed(r_a) < $signed(r_b));
    assign a_eq_b = (r_a == r_b);
    assign a_full = (r_cnt_a >= DEPTH_C);
    assign b_full = (r_cnt_b >= DEPTH_C);

    always_comb begin
        inc_i    = 1'b0;
        inc_j    = 1'b0;
        emit     = 1'b0;
        emit_val = r_a;
        if (has_a && has_b) begin
            if (r_setop == SETOP_MERGE) begin
                emit = 1'b1;
                if (a_lt_b) begin
                    inc_i = 1'b1;
                end else begin
                    inc_j    = 1'b1;
                    emit_val = r_b;
                end
            end else if (a_eq_b) begin
                emit  = (r_setop == SETOP_UNION) || (r_setop == SETOP_INTERSECT);
                inc_i = 1'b1;
                inc_j = 1'b1;
            end else if (a_lt_b) begin
                emit  = (r_setop != SETOP_INTERSECT);
                inc_i = 1'b1;
            end else begin
                emit     = (r_setop == SETOP_UNION);
                emit_val = r_b;
                inc_j    = 1'b1;
            end
        end else if (has_a && (r_setop != SETOP_INTERSECT)) begin
            emit  = 1'b1;
            inc_i = 1'b1;
        end else if (has_b && ((r_setop == SETOP_MERGE) || (r_setop == SETOP_UNION))) begin
            emit     = 1'b1;
            emit_val = r_b;
            inc_j    = 1'b1;
        end
    end

    assign o_stat.slot_free = !r_out_valid || i_m_tready;
    assign o_stat.walk_done = !(inc_i || inc_j);

    assign push = (i_cmd.step && emit && r_pend_valid) || i_cmd.finish;

    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_dropped    = r_dropped;
        n_i          = r_i;
        n_j          = r_j;
        n_pend_valid = r_pend_valid;
        n_pend_val   = r_pend_val;
        n_out_valid  = (r_out_valid && !i_m_tready) || push;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_ovf    = r_out_ovf;

        if (i_cmd.load_a) begin
            if (a_full) n_dropped = 1'b1;
            else        n_cnt_a   = r_cnt_a + CW'(1);
        end
        if (i_cmd.load_b) begin
            if (b_full) n_dropped = 1'b1;
            else        n_cnt_b   = r_cnt_b + CW'(1);
        end
        if (i_cmd.start) begin
            n_i          = '0;
            n_j          = '0;
            n_pend_valid = 1'b0;
        end
        if (i_cmd.step) begin
            n_i = r_i + CW'(inc_i);
            n_j = r_j + CW'(inc_j);
            if (emit) begin
                n_pend_valid = 1'b1;
                n_pend_val   = emit_val;
                if (r_pend_valid) begin
                    n_out_val   = r_pend_val;
                    n_out_last  = 1'b0;
                    n_out_empty = 1'b0;
                    n_out_ovf   = r_dropped;
                end
            end
        end
        if (i_cmd.finish) begin
            n_out_val    = r_pend_valid ? r_pend_val : '0;
            n_out_last   = 1'b1;
            n_out_empty  = !r_pend_valid;
            n_out_ovf    = r_dropped;
            n_pend_valid = 1'b0;
            n_cnt_a      = '0;
            n_cnt_b      = '0;
            n_dropped    = 1'b0;
            n_i          = '0;
            n_j          = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && !a_full) begin
            mem_a[r_cnt_a[IW-1:0]] <= i_value;
        end
        if (i_cmd.load_b && !b_full) begin
            mem_b[r_cnt_b[IW-1:0]] <= i_value;
        end
        r_a <= mem_a[n_i[IW-1:0]];
        r_b <= mem_b[n_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setop      <= SETOP_MERGE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_dropped    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_setop <= i_cfg_wr_data;
            end
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_i          <= n_i;
            r_j          <= n_j;
            r_dropped    <= n_dropped;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_val  <= n_pend_val;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_val;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_ovf, r_out_empty};

    `SSME_ASSERT_SAME(a_ptr_in_range, i_clk, i_rst_n, 1'b1, (r_i <= r_cnt_a) && (r_j <= r_cnt_b))
    `SSME_ASSERT_SAME(a_push_has_slot, i_clk, i_rst_n, push, o_stat.slot_free)
    `SSME_ASSERT_NEXT(a_finish_gives_last, i_clk, i_rst_n, i_cmd.finish, r_out_valid && r_out_last && !r_pend_valid)
    `SSME_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, i_cmd.finish, (r_cnt_a == '0) && (r_cnt_b == '0) && !r_dropped)

endmodule

// ===== sv/sorted_set_merge_engine.sv =====
// Top level of the sorted set merge engine: controller plus datapath.
// Depends on ssme_pkg, ssme_ctrl and ssme_dp.
//
// Channel   Direction  tdata (low bit up)  tuser (low bit up)       tlast
// s_axis    in         value[31:0]         opcode[1:0]              -
// m_axis    out        out_value[31:0]     empty_res, overflow      last
// cfg       in         set_operation[1:0]  -                        -
//
// Loads are accepted back to back while no run is active.
// A run first primes the list read registers, then performs the walk steps (at most
// the sum of both list counts) and a final step that puts out the last word.
// A stalled output holds the walk; the input is not ready until the run's last word
// is in the output register. Reset is synchronous and active low.
`timescale 1ns / 1ps

module sorted_set_merge_engine #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [ssme_pkg::VALUE_W-1:0]        i_s_axis_tdata,  // value
    input  logic [ssme_pkg::OPC_W-1:0]          i_s_axis_tuser,  // opcode
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ssme_pkg::VALUE_W-1:0]        o_m_axis_tdata,  // out_value
    output logic                                o_m_axis_tlast,
    output logic [1:0]                          o_m_axis_tuser,  // empty_res, overflow
    input  logic                                i_cfg_wr_en,
    input  logic [ssme_pkg::SETOP_W-1:0]        i_cfg_wr_data
);
    import ssme_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ssme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tuser  (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssme_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_value       (i_s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tvalid    (o_m_axis_tvalid),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_tlast     (o_m_axis_tlast),
        .o_m_tuser     (o_m_axis_tuser)
    );

endmodule
